### src/tac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_pkg
// Types, class codes and helpers shared by the Thumb ALU instruction
// classifier and its channel interfaces.
// ----------------------------------------------------------------------------
package tac_pkg;

    typedef enum logic [4:0] {
        CLS_ADD = 5'd0,
        CLS_SUB = 5'd1,
        CLS_RSB = 5'd2,
        CLS_ADC = 5'd3,
        CLS_SBC = 5'd4,
        CLS_AND = 5'd5,
        CLS_ORR = 5'd6,
        CLS_EOR = 5'd7,
        CLS_BIC = 5'd8,
        CLS_MVN = 5'd9,
        CLS_MUL = 5'd10,
        CLS_DIV = 5'd11,
        CLS_LSL = 5'd12,
        CLS_LSR = 5'd13,
        CLS_ASR = 5'd14,
        CLS_ROR = 5'd15,
        CLS_CMP = 5'd16,
        CLS_CMN = 5'd17,
        CLS_TST = 5'd18,
        CLS_TEQ = 5'd19,
        CLS_STR = 5'd20
    } t_class;

    typedef logic [3:0] t_reg_idx;

    typedef struct packed {
        logic        matched;
        t_class      insn_class;
        logic        writes_register;
        t_reg_idx    first_reg;
        logic        second_reg_valid;
        t_reg_idx    second_reg;
        logic        imm_valid;
        logic [31:0] compare_imm;
        logic [2:0]  store_bytes;
    } t_result;

    localparam logic [2:0] STORE_BYTE = 3'd1;
    localparam logic [2:0] STORE_HALF = 3'd2;
    localparam logic [2:0] STORE_WORD = 3'd4;

    // class of the narrow data-processing group, by opcode
    function automatic t_class f_narrow_dp_class(input logic [3:0] op);
        t_class c;
        begin
            case (op)
                4'h0:    c = CLS_AND;
                4'h1:    c = CLS_EOR;
                4'h2:    c = CLS_LSL;
                4'h3:    c = CLS_LSR;
                4'h4:    c = CLS_ASR;
                4'h5:    c = CLS_ADC;
                4'h6:    c = CLS_SBC;
                4'h7:    c = CLS_ROR;
                4'h8:    c = CLS_TST;
                4'h9:    c = CLS_RSB;
                4'hA:    c = CLS_CMP;
                4'hB:    c = CLS_CMN;
                4'hC:    c = CLS_ORR;
                4'hD:    c = CLS_MUL;
                4'hE:    c = CLS_BIC;
                default: c = CLS_MVN;
            endcase
            return c;
        end
    endfunction

    function automatic t_class f_shift_class(input logic [1:0] ty);
        t_class c;
        begin
            case (ty)
                2'd0:    c = CLS_LSL;
                2'd1:    c = CLS_LSR;
                2'd2:    c = CLS_ASR;
                default: c = CLS_ROR;
            endcase
            return c;
        end
    endfunction

    // thumb modified-immediate expansion
    function automatic logic [31:0] f_expand_imm(input logic [11:0] imm12);
        logic [7:0]  b;
        logic [31:0] v;
        logic [63:0] rot_word;
        logic [31:0] res;
        begin
            b        = imm12[7:0];
            v        = {24'd0, 1'b1, b[6:0]};
            rot_word = {v, v} >> imm12[11:7];
            case (imm12[11:8])
                4'h0:    res = {24'd0, b};
                4'h1:    res = {8'd0, b, 8'd0, b};
                4'h2:    res = {b, 8'd0, b, 8'd0};
                4'h3:    res = {b, b, b, b};
                default: res = rot_word[31:0];
            endcase
            return res;
        end
    endfunction

endpackage
`default_nettype wire

### src/tac_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac channel interfaces
// Valid/ready channels carrying instruction words in and class words out.
// ----------------------------------------------------------------------------
interface tac_in_if
    import tac_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic        is_wide;

    modport source (output valid, output first_half, output second_half,
                    output is_wide, input ready);
    modport sink   (input valid, input first_half, input second_half,
                    input is_wide, output ready);
endinterface

interface tac_out_if
    import tac_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        matched;
    t_class      insn_class;
    logic        writes_register;
    t_reg_idx    first_reg;
    logic        second_reg_valid;
    t_reg_idx    second_reg;
    logic        imm_valid;
    logic [31:0] compare_imm;
    logic [2:0]  store_bytes;

    modport source (output valid, output matched, output insn_class,
                    output writes_register, output first_reg,
                    output second_reg_valid, output second_reg,
                    output imm_valid, output compare_imm, output store_bytes,
                    input ready);
    modport sink   (input valid, input matched, input insn_class,
                    input writes_register, input first_reg,
                    input second_reg_valid, input second_reg,
                    input imm_valid, input compare_imm, input store_bytes,
                    output ready);
endinterface
`default_nettype wire

### src/thumb_alu_insn_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_alu_insn_classifier
// Sorts one Thumb instruction per word into an ALU, compare or store class.
// ----------------------------------------------------------------------------
// Input channel i_in carries one instruction word: first and second halfword
// and a wide flag. Output channel o_out carries one class word per input word,
// in order: match flag, class, written/compared/stored register, second
// compare register or expanded immediate, and store size.
// The block is two registers deep: the input word is captured, decoded by
// combinational logic, and the result lands in the output register. o_out.valid
// rises once the output register takes the decoded word from the input
// register; throughput is one word every cycle while the receiver does not
// stall, set by the single decode pass between the two registers.
// When the receiver stalls the output register holds its word and the input
// register keeps accepting until it is full, so ready drops only once both
// stages hold a word. Reset (i_rst_n low, synchronous) empties both stages;
// the block keeps no other state.
// ----------------------------------------------------------------------------
module thumb_alu_insn_classifier
    import tac_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    tac_in_if.sink     i_in,
    tac_out_if.source  o_out
);

    logic        r_s1_valid;
    logic [15:0] r_s1_first_half;
    logic [15:0] r_s1_second_half;
    logic        r_s1_is_wide;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        out_free;
    logic        advance;

    function automatic t_result f_write(input t_class c, input t_reg_idx rd);
        t_result r;
        begin
            r                 = '0;
            r.matched         = 1'b1;
            r.insn_class      = c;
            r.writes_register = 1'b1;
            r.first_reg       = rd;
            return r;
        end
    endfunction

    function automatic t_result f_cmp_reg(input t_class c, input t_reg_idx rn,
                                          input t_reg_idx rm);
        t_result r;
        begin
            r                  = '0;
            r.matched          = 1'b1;
            r.insn_class       = c;
            r.first_reg        = rn;
            r.second_reg_valid = 1'b1;
            r.second_reg       = rm;
            return r;
        end
    endfunction

    function automatic t_result f_cmp_imm(input t_class c, input t_reg_idx rn,
                                          input logic [31:0] imm);
        t_result r;
        begin
            r             = '0;
            r.matched     = 1'b1;
            r.insn_class  = c;
            r.first_reg   = rn;
            r.imm_valid   = 1'b1;
            r.compare_imm = imm;
            return r;
        end
    endfunction

    function automatic t_result f_store(input t_reg_idx rt, input logic [2:0] nb);
        t_result r;
        begin
            r             = '0;
            r.matched     = 1'b1;
            r.insn_class  = CLS_STR;
            r.first_reg   = rt;
            r.store_bytes = nb;
            return r;
        end
    endfunction

    function automatic t_result f_narrow(input logic [15:0] h);
        t_result  r;
        t_reg_idx rdn;
        begin
            r   = '0;
            rdn = {h[7], h[2:0]};
            if (h[15:10] == 6'b010000) begin
                if (h[9:6] == 4'h8 || h[9:6] == 4'hA || h[9:6] == 4'hB) begin
                    r = f_cmp_reg(f_narrow_dp_class(h[9:6]), {1'b0, h[2:0]},
                                  {1'b0, h[5:3]});
                end else begin
                    r = f_write(f_narrow_dp_class(h[9:6]), {1'b0, h[2:0]});
                end
            end else if (h[15:13] == 3'b000 && h[12:11] != 2'b11) begin
                // lsl by zero is a register move
                if (!(h[12:11] == 2'b00 && h[10:6] == 5'd0)) begin
                    r = f_write(f_shift_class(h[12:11]), {1'b0, h[2:0]});
                end
            end else if (h[15:11] == 5'b00011) begin
                r = f_write(h[9] ? CLS_SUB : CLS_ADD, {1'b0, h[2:0]});
            end else if (h[15:13] == 3'b001) begin
                case (h[12:11])
                    2'd1:    r = f_cmp_imm(CLS_CMP, {1'b0, h[10:8]}, {24'd0, h[7:0]});
                    2'd2:    r = f_write(CLS_ADD, {1'b0, h[10:8]});
                    2'd3:    r = f_write(CLS_SUB, {1'b0, h[10:8]});
                    default: r = '0;
                endcase
            end else if (h[15:9] == 7'b0100010) begin
                if (h[8]) begin
                    r = f_cmp_reg(CLS_CMP, rdn, h[6:3]);
                end else if (rdn != 4'd13 && rdn != 4'd15) begin
                    r = f_write(CLS_ADD, rdn);
                end
            end else if (h[15:9] == 7'b0101000) begin
                r = f_store({1'b0, h[2:0]}, STORE_WORD);
            end else if (h[15:9] == 7'b0101001) begin
                r = f_store({1'b0, h[2:0]}, STORE_HALF);
            end else if (h[15:9] == 7'b0101010) begin
                r = f_store({1'b0, h[2:0]}, STORE_BYTE);
            end else if (h[15:11] == 5'b01100) begin
                r = f_store({1'b0, h[2:0]}, STORE_WORD);
            end else if (h[15:11] == 5'b01110) begin
                r = f_store({1'b0, h[2:0]}, STORE_BYTE);
            end else if (h[15:11] == 5'b10000) begin
                r = f_store({1'b0, h[2:0]}, STORE_HALF);
            end else if (h[15:11] == 5'b10010) begin
                r = f_store({1'b0, h[10:8]}, STORE_WORD);
            end
            return r;
        end
    endfunction

    // opcode table shared by the wide register and modified-immediate groups
    function automatic t_result f_wide_dp(input logic [3:0] op, input logic s,
                                          input t_reg_idx rn, input t_reg_idx rd,
                                          input logic is_reg, input t_reg_idx rm,
                                          input logic [11:0] imm12);
        t_result r;
        logic    special;
        logic    is_cmp;
        t_class  cmp_cls;
        begin
            r       = '0;
            special = s && (rd == 4'hF);
            is_cmp  = 1'b0;
            cmp_cls = CLS_CMP;
            case (op)
                4'h0: begin
                    if (special) begin
                        is_cmp  = 1'b1;
                        cmp_cls = CLS_TST;
                    end else begin
                        r = f_write(CLS_AND, rd);
                    end
                end
                4'h1: r = f_write(CLS_BIC, rd);
                4'h2: begin
                    if (rn != 4'hF) begin
                        r = f_write(CLS_ORR, rd);
                    end
                end
                4'h3: r = f_write((rn == 4'hF) ? CLS_MVN : CLS_ORR, rd);
                4'h4: begin
                    if (special) begin
                        is_cmp  = 1'b1;
                        cmp_cls = CLS_TEQ;
                    end else begin
                        r = f_write(CLS_EOR, rd);
                    end
                end
                4'h8: begin
                    if (special) begin
                        is_cmp  = 1'b1;
                        cmp_cls = CLS_CMN;
                    end else if (rn != 4'd13) begin
                        r = f_write(CLS_ADD, rd);
                    end
                end
                4'hA: r = f_write(CLS_ADC, rd);
                4'hB: r = f_write(CLS_SBC, rd);
                4'hD: begin
                    if (special) begin
                        is_cmp  = 1'b1;
                        cmp_cls = CLS_CMP;
                    end else if (rn != 4'd13) begin
                        r = f_write(CLS_SUB, rd);
                    end
                end
                4'hE: r = f_write(CLS_RSB, rd);
                default: r = '0;
            endcase
            if (is_cmp) begin
                if (is_reg) begin
                    r = f_cmp_reg(cmp_cls, rn, rm);
                end else begin
                    r = f_cmp_imm(cmp_cls, rn, f_expand_imm(imm12));
                end
            end
            return r;
        end
    endfunction

    function automatic t_result f_wide(input logic [15:0] a, input logic [15:0] b);
        t_result     r;
        t_reg_idx    rd;
        t_reg_idx    rn;
        logic [11:0] t;
        logic [11:0] imm12;
        begin
            r     = '0;
            rd    = b[11:8];
            rn    = a[3:0];
            t     = a[15:4];
            imm12 = {a[10], b[14:12], b[7:0]};
            if (a[15:7] == 9'b111110100 && b[15:12] == 4'hF && b[7:4] == 4'h0) begin
                r = f_write(f_shift_class(a[6:5]), rd);
            end else if (a[15:9] == 7'b1110101) begin
                if (a[8:5] == 4'h2 && rn == 4'hF) begin
                    // move with shift; plain move when shift is lsl by zero
                    if (!(b[5:4] == 2'b00 && b[14:12] == 3'd0 && b[7:6] == 2'd0)) begin
                        r = f_write(f_shift_class(b[5:4]), rd);
                    end
                end else begin
                    r = f_wide_dp(a[8:5], a[4], rn, rd, 1'b1, b[3:0], 12'd0);
                end
            end else if (a[15:11] == 5'b11110 && !a[9] && !b[15]) begin
                if (!(a[8:5] == 4'h2 && rn == 4'hF)) begin
                    r = f_wide_dp(a[8:5], a[4], rn, rd, 1'b0, 4'd0, imm12);
                end
            end else if (a[15:11] == 5'b11110
                         && (a[9:4] == 6'b100000 || a[9:4] == 6'b101010)) begin
                if (rn != 4'hF && rn != 4'd13) begin
                    r = f_write((a[9:4] == 6'b100000) ? CLS_ADD : CLS_SUB, rd);
                end
            end else if (t == 12'hF80 || t == 12'hF88) begin
                r = f_store(b[15:12], STORE_BYTE);
            end else if (t == 12'hF82 || t == 12'hF8A) begin
                r = f_store(b[15:12], STORE_HALF);
            end else if (t == 12'hF84 || t == 12'hF8C) begin
                r = f_store(b[15:12], STORE_WORD);
            end else if (t == 12'hFB0) begin
                if (b[7:5] == 3'd0) begin
                    r = f_write(CLS_MUL, rd);
                end
            end else if ((t == 12'hFB9 || t == 12'hFBB)
                         && b[15:12] == 4'hF && b[7:4] == 4'hF) begin
                r = f_write(CLS_DIV, rd);
            end
            return r;
        end
    endfunction

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    always_comb begin
        if (r_s1_is_wide) begin
            n_out = f_wide(r_s1_first_half, r_s1_second_half);
        end else begin
            n_out = f_narrow(r_s1_first_half);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_first_half  <= i_in.first_half;
            r_s1_second_half <= i_in.second_half;
            r_s1_is_wide     <= i_in.is_wide;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_out.matched;
    assign o_out.insn_class       = r_out.insn_class;
    assign o_out.writes_register  = r_out.writes_register;
    assign o_out.first_reg        = r_out.first_reg;
    assign o_out.second_reg_valid = r_out.second_reg_valid;
    assign o_out.second_reg       = r_out.second_reg;
    assign o_out.imm_valid        = r_out.imm_valid;
    assign o_out.compare_imm      = r_out.compare_imm;
    assign o_out.store_bytes      = r_out.store_bytes;

endmodule
`default_nettype wire
